[rtl/crowd_agent_goal_velocity_step_defines.svh]
// ----------------------------------------------------------------------------
// Assertion macros for the crowd agent goal velocity step
// Shared concurrent assertion forms, clocked on clk_i and disabled in reset.
// ----------------------------------------------------------------------------
`ifndef CROWD_AGENT_GOAL_VELOCITY_STEP_DEFINES_SVH
`define CROWD_AGENT_GOAL_VELOCITY_STEP_DEFINES_SVH

// The consequent must hold in the same cycle as the antecedent.
`define CAGV_ASSERT_IMPLY(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("%m: implication check failed");

// The consequent must hold a fixed number of cycles after the antecedent.
`define CAGV_ASSERT_DELAY(lbl, ante, dly, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> ##(dly) (cons)) \
    else $error("%m: delayed check failed");

`endif

[rtl/cagv_pkg.sv]
// ----------------------------------------------------------------------------
// Crowd agent goal velocity step package
// Widths, constants, stage payload types and saturation helpers.
// ----------------------------------------------------------------------------
package cagv_pkg;

  localparam int unsigned DataW     = 32;
  localparam int unsigned UW        = 31;
  localparam int unsigned AddrW     = 3;
  localparam int unsigned RootW     = 33;
  localparam int unsigned RadW      = 2 * RootW;
  localparam int unsigned RemW      = RootW + 3;
  localparam int unsigned SqrtSteps = RootW;
  localparam int unsigned NumW      = 64;
  localparam int unsigned DenW      = 33;
  localparam int unsigned QuotW     = 32;
  localparam int unsigned DivSteps  = QuotW;
  localparam int unsigned DivLanes  = 4;
  localparam int unsigned SatW      = 52;

  localparam logic [UW-1:0] TimeStepReset = 31'd6554;
  localparam logic [15:0]   BlendQ16      = 16'd26214;

  localparam logic signed [DataW-1:0] S32Max = 32'sh7fff_ffff;
  localparam logic signed [DataW-1:0] S32Min = 32'sh8000_0000;
  localparam logic signed [SatW-1:0]  SatHi  = 52'sd2147483647;
  localparam logic signed [SatW-1:0]  SatLo  = -52'sd2147483648;

  typedef enum logic [0:0] {
    RegTimeStep = 1'b0
  } reg_idx_e;

  typedef struct packed {
    logic              arrived;
    logic              vzero;
    logic              dsx;
    logic              dsy;
    logic [31:0]       mx;
    logic [31:0]       my;
    logic [62:0]       pnx;
    logic [62:0]       pny;
    logic [61:0]       reach;
    logic              vsx;
    logic              vsy;
    logic [31:0]       avx;
    logic [31:0]       avy;
    logic [DataW-1:0]  npx;
    logic [DataW-1:0]  npy;
    logic [DataW-1:0]  ox;
    logic [DataW-1:0]  oy;
  } sq_pay_t;

  typedef struct packed {
    logic              arrived;
    logic              keep;
    logic [DataW-1:0]  npx;
    logic [DataW-1:0]  npy;
    logic [DataW-1:0]  ox;
    logic [DataW-1:0]  oy;
  } dv_pay_t;

  typedef struct packed {
    logic              neg;
    logic [NumW-1:0]   num;
    logic [DenW-1:0]   den;
  } div_op_t;

  typedef struct packed {
    logic              neg;
    logic              ovf;
    logic [QuotW-1:0]  quo;
  } div_res_t;

  function automatic logic [DataW-1:0] sat32(input logic signed [SatW-1:0] v);
    logic [DataW-1:0] r;
    if (v > SatHi) begin
      r = S32Max;
    end else if (v < SatLo) begin
      r = S32Min;
    end else begin
      r = v[DataW-1:0];
    end
    return r;
  endfunction

  function automatic logic [DataW-1:0] quo_to_s32(input div_res_t r);
    logic [DataW-1:0] v;
    if (r.ovf) begin
      v = r.neg ? S32Min : S32Max;
    end else if (r.neg) begin
      v = (r.quo > 32'h8000_0000) ? S32Min : (32'h0 - r.quo);
    end else begin
      v = (r.quo > 32'h7fff_ffff) ? S32Max : r.quo;
    end
    return v;
  endfunction

endpackage

[rtl/cagv_cfg_regs.sv]
// ----------------------------------------------------------------------------
// Configuration registers
// APB-style register file holding the simulation time step.
// ----------------------------------------------------------------------------
module cagv_cfg_regs
  import cagv_pkg::*;
(
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             psel,
  input  logic             penable,
  input  logic             pwrite,
  input  logic [AddrW-1:0] paddr,
  input  logic [31:0]      pwdata,
  output logic [31:0]      prdata,
  output logic             pready,
  output logic [UW-1:0]    time_step_o
);

  logic [UW-1:0] time_step_q;
  logic          wr_en;

  assign pready      = 1'b1;
  assign wr_en       = psel && penable && pwrite &&
                       (reg_idx_e'(paddr[AddrW-1:2]) == RegTimeStep);
  assign time_step_o = time_step_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      time_step_q <= TimeStepReset;
    end else if (wr_en) begin
      time_step_q <= pwdata[UW-1:0];
    end
  end

  always_comb begin
    unique case (reg_idx_e'(paddr[AddrW-1:2]))
      RegTimeStep: prdata = {1'b0, time_step_q};
      default:     prdata = '0;
    endcase
  end

endmodule

[rtl/cagv_sqrt_pipe.sv]
// ----------------------------------------------------------------------------
// Pipelined integer square root
// Two lanes of a digit-by-digit root, one result bit per register stage.
// ----------------------------------------------------------------------------
module cagv_sqrt_pipe
  import cagv_pkg::*;
(
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  vld_i,
  input  logic [1:0][RadW-1:0]  rad_i,
  input  sq_pay_t               pay_i,
  output logic                  vld_o,
  output logic [1:0][RootW-1:0] root_o,
  output sq_pay_t               pay_o
);

  logic                  vld_q  [SqrtSteps];
  sq_pay_t               pay_q  [SqrtSteps];
  logic [1:0][RootW-1:0] root_q [SqrtSteps];
  logic [1:0][RemW-1:0]  rem_q  [SqrtSteps-1];
  logic [1:0][RadW-1:0]  rad_q  [SqrtSteps-1];

  for (genvar k = 0; k < SqrtSteps; k++) begin : g_step
    logic                  vld_in;
    sq_pay_t               pay_in;
    logic [1:0][RadW-1:0]  rad_in;
    logic [1:0][RemW-1:0]  rem_in;
    logic [1:0][RemW-1:0]  cur;
    logic [1:0][RemW-1:0]  trial;
    logic [1:0][RemW-1:0]  rem_d;
    logic [1:0][RootW-1:0] root_in;
    logic [1:0][RootW-1:0] root_d;

    if (k == 0) begin : g_head
      assign vld_in  = vld_i;
      assign pay_in  = pay_i;
      assign rad_in  = rad_i;
      assign rem_in  = '0;
      assign root_in = '0;
    end else begin : g_body
      assign vld_in  = vld_q[k-1];
      assign pay_in  = pay_q[k-1];
      assign rad_in  = rad_q[k-1];
      assign rem_in  = rem_q[k-1];
      assign root_in = root_q[k-1];
    end

    always_comb begin
      for (int l = 0; l < 2; l++) begin
        cur[l]   = {rem_in[l][RemW-3:0], rad_in[l][2*(SqrtSteps-1-k)+1 -: 2]};
        trial[l] = {1'b0, root_in[l], 2'b01};
        if (cur[l] >= trial[l]) begin
          rem_d[l]  = cur[l] - trial[l];
          root_d[l] = {root_in[l][RootW-2:0], 1'b1};
        end else begin
          rem_d[l]  = cur[l];
          root_d[l] = {root_in[l][RootW-2:0], 1'b0};
        end
      end
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        vld_q[k] <= 1'b0;
      end else begin
        vld_q[k] <= vld_in;
      end
    end

    always_ff @(posedge clk_i) begin
      pay_q[k]  <= pay_in;
      root_q[k] <= root_d;
    end

    if (k < SqrtSteps - 1) begin : g_fwd
      always_ff @(posedge clk_i) begin
        rem_q[k] <= rem_d;
        rad_q[k] <= rad_in;
      end
    end
  end

  assign vld_o  = vld_q[SqrtSteps-1];
  assign root_o = root_q[SqrtSteps-1];
  assign pay_o  = pay_q[SqrtSteps-1];

endmodule

[rtl/cagv_div_pipe.sv]
// ----------------------------------------------------------------------------
// Pipelined unsigned divider
// Four lanes of restoring division with an overflow check stage up front
// and one quotient bit per register stage after it.
// ----------------------------------------------------------------------------
module cagv_div_pipe
  import cagv_pkg::*;
(
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     vld_i,
  input  div_op_t [DivLanes-1:0]   op_i,
  input  dv_pay_t                  pay_i,
  output logic                     vld_o,
  output div_res_t [DivLanes-1:0]  res_o,
  output dv_pay_t                  pay_o
);

  logic                           vld_q  [DivSteps+1];
  dv_pay_t                        pay_q  [DivSteps+1];
  logic [DivLanes-1:0]            neg_q  [DivSteps+1];
  logic [DivLanes-1:0]            ovf_q  [DivSteps+1];
  logic [DivLanes-1:0]            zero_q [DivSteps+1];
  logic [DivLanes-1:0][DenW-1:0]  den_q  [DivSteps];
  logic [DivLanes-1:0][DenW-1:0]  rem_q  [DivSteps];
  logic [DivLanes-1:0][QuotW-1:0] low_q  [DivSteps];
  logic [DivLanes-1:0][QuotW-1:0] quo_q  [1:DivSteps];

  logic [DivLanes-1:0]            pre_ovf;
  logic [DivLanes-1:0]            pre_zero;
  logic [DivLanes-1:0]            pre_neg;

  always_comb begin
    for (int l = 0; l < DivLanes; l++) begin
      pre_zero[l] = (op_i[l].den == '0);
      pre_ovf[l]  = !pre_zero[l] && ({1'b0, op_i[l].num} >= {op_i[l].den, 32'h0});
      pre_neg[l]  = op_i[l].neg;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q[0] <= 1'b0;
    end else begin
      vld_q[0] <= vld_i;
    end
  end

  always_ff @(posedge clk_i) begin
    pay_q[0]  <= pay_i;
    neg_q[0]  <= pre_neg;
    ovf_q[0]  <= pre_ovf;
    zero_q[0] <= pre_zero;
    for (int l = 0; l < DivLanes; l++) begin
      den_q[0][l] <= op_i[l].den;
      rem_q[0][l] <= {1'b0, op_i[l].num[NumW-1:QuotW]};
      low_q[0][l] <= op_i[l].num[QuotW-1:0];
    end
  end

  for (genvar k = 1; k <= DivSteps; k++) begin : g_step
    logic [DivLanes-1:0][QuotW-1:0] quo_in;
    logic [DivLanes-1:0][QuotW-1:0] quo_d;
    logic [DivLanes-1:0][DenW:0]    ext;
    logic [DivLanes-1:0][DenW-1:0]  rem_d;

    if (k == 1) begin : g_head
      assign quo_in = '0;
    end else begin : g_body
      assign quo_in = quo_q[k-1];
    end

    always_comb begin
      for (int l = 0; l < DivLanes; l++) begin
        ext[l] = {rem_q[k-1][l], low_q[k-1][l][QuotW-k]};
        if (ext[l] >= {1'b0, den_q[k-1][l]}) begin
          rem_d[l] = DenW'(ext[l] - {1'b0, den_q[k-1][l]});
          quo_d[l] = {quo_in[l][QuotW-2:0], 1'b1};
        end else begin
          rem_d[l] = ext[l][DenW-1:0];
          quo_d[l] = {quo_in[l][QuotW-2:0], 1'b0};
        end
      end
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        vld_q[k] <= 1'b0;
      end else begin
        vld_q[k] <= vld_q[k-1];
      end
    end

    always_ff @(posedge clk_i) begin
      pay_q[k]  <= pay_q[k-1];
      neg_q[k]  <= neg_q[k-1];
      ovf_q[k]  <= ovf_q[k-1];
      zero_q[k] <= zero_q[k-1];
      quo_q[k]  <= quo_d;
    end

    if (k < DivSteps) begin : g_fwd
      always_ff @(posedge clk_i) begin
        den_q[k] <= den_q[k-1];
        rem_q[k] <= rem_d;
        low_q[k] <= low_q[k-1];
      end
    end
  end

  always_comb begin
    for (int l = 0; l < DivLanes; l++) begin
      res_o[l].neg = neg_q[DivSteps][l];
      res_o[l].ovf = ovf_q[DivSteps][l];
      res_o[l].quo = zero_q[DivSteps][l] ? '0 : quo_q[DivSteps][l];
    end
  end

  assign vld_o = vld_q[DivSteps];
  assign pay_o = pay_q[DivSteps];

endmodule

[rtl/crowd_agent_goal_velocity_step.sv]
// Throughput: one request per cycle; busy stays low, the pipeline never stalls.
// Depth is set by the 33-stage square root and the 33-stage divider.
// Reset clears all stage valid bits and loads time_step with 6554.
// The receiver cannot stall; each result is shown for one cycle only.
// ----------------------------------------------------------------------------
// Crowd agent goal velocity and Euler step
// Goal test, preferred velocity, position advance and orientation blend
// for one agent per cycle in signed Q16.16.
// ----------------------------------------------------------------------------
module crowd_agent_goal_velocity_step
  import cagv_pkg::*;
(
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             psel,
  input  logic             penable,
  input  logic             pwrite,
  input  logic [AddrW-1:0] paddr,
  input  logic [31:0]      pwdata,
  output logic [31:0]      prdata,
  output logic             pready,
  input  logic             start,
  output logic             busy,
  input  logic [31:0]      pos_x_i,
  input  logic [31:0]      pos_y_i,
  input  logic [31:0]      goal_x_i,
  input  logic [31:0]      goal_y_i,
  input  logic [31:0]      vel_x_i,
  input  logic [31:0]      vel_y_i,
  input  logic [31:0]      orient_x_i,
  input  logic [31:0]      orient_y_i,
  input  logic [30:0]      pref_speed_i,
  input  logic [30:0]      goal_radius_sq_i,
  output logic             done_o,
  output logic [31:0]      pref_vel_x_o,
  output logic [31:0]      pref_vel_y_o,
  output logic             arrived_o,
  output logic [31:0]      new_pos_x_o,
  output logic [31:0]      new_pos_y_o,
  output logic [31:0]      new_orient_x_o,
  output logic [31:0]      new_orient_y_o
);

  `include "crowd_agent_goal_velocity_step_defines.svh"

  logic [UW-1:0] dt;

  cagv_cfg_regs u_cfg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .psel        (psel),
    .penable     (penable),
    .pwrite      (pwrite),
    .paddr       (paddr),
    .pwdata      (pwdata),
    .prdata      (prdata),
    .pready      (pready),
    .time_step_o (dt)
  );

  assign busy = 1'b0;

  // Stage 1: goal offset and magnitudes.
  logic        s1_vld_q;
  logic        s1_dsx_q, s1_dsy_q, s1_vsx_q, s1_vsy_q, s1_vzero_q;
  logic [31:0] s1_mx_q, s1_my_q, s1_avx_q, s1_avy_q;
  logic [31:0] s1_px_q, s1_py_q, s1_ox_q, s1_oy_q;
  logic [30:0] s1_ps_q, s1_rsq_q;
  logic [32:0] dx_d, dy_d, mx_d, my_d;

  assign dx_d = {goal_x_i[31], goal_x_i} - {pos_x_i[31], pos_x_i};
  assign dy_d = {goal_y_i[31], goal_y_i} - {pos_y_i[31], pos_y_i};
  assign mx_d = dx_d[32] ? (33'h0 - dx_d) : dx_d;
  assign my_d = dy_d[32] ? (33'h0 - dy_d) : dy_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_vld_q <= 1'b0;
    end else begin
      s1_vld_q <= start && !busy;
    end
  end

  always_ff @(posedge clk_i) begin
    s1_dsx_q   <= dx_d[32];
    s1_dsy_q   <= dy_d[32];
    s1_mx_q    <= mx_d[31:0];
    s1_my_q    <= my_d[31:0];
    s1_vsx_q   <= vel_x_i[31];
    s1_vsy_q   <= vel_y_i[31];
    s1_avx_q   <= vel_x_i[31] ? (32'h0 - vel_x_i) : vel_x_i;
    s1_avy_q   <= vel_y_i[31] ? (32'h0 - vel_y_i) : vel_y_i;
    s1_vzero_q <= (vel_x_i == '0) && (vel_y_i == '0);
    s1_px_q    <= pos_x_i;
    s1_py_q    <= pos_y_i;
    s1_ox_q    <= orient_x_i;
    s1_oy_q    <= orient_y_i;
    s1_ps_q    <= pref_speed_i;
    s1_rsq_q   <= goal_radius_sq_i;
  end

  // Stage 2: products.
  logic        s2_vld_q;
  logic        s2_dsx_q, s2_dsy_q, s2_vsx_q, s2_vsy_q, s2_vzero_q;
  logic [31:0] s2_mx_q, s2_my_q, s2_avx_q, s2_avy_q;
  logic [31:0] s2_px_q, s2_py_q, s2_ox_q, s2_oy_q;
  logic [30:0] s2_rsq_q;
  logic [63:0] s2_sx_q, s2_sy_q, s2_vsqx_q, s2_vsqy_q;
  logic [62:0] s2_pnx_q, s2_pny_q, s2_dvx_q, s2_dvy_q;
  logic [61:0] s2_reach_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s2_vld_q <= 1'b0;
    end else begin
      s2_vld_q <= s1_vld_q;
    end
  end

  always_ff @(posedge clk_i) begin
    s2_dsx_q   <= s1_dsx_q;
    s2_dsy_q   <= s1_dsy_q;
    s2_vsx_q   <= s1_vsx_q;
    s2_vsy_q   <= s1_vsy_q;
    s2_vzero_q <= s1_vzero_q;
    s2_mx_q    <= s1_mx_q;
    s2_my_q    <= s1_my_q;
    s2_avx_q   <= s1_avx_q;
    s2_avy_q   <= s1_avy_q;
    s2_px_q    <= s1_px_q;
    s2_py_q    <= s1_py_q;
    s2_ox_q    <= s1_ox_q;
    s2_oy_q    <= s1_oy_q;
    s2_rsq_q   <= s1_rsq_q;
    s2_sx_q    <= 64'(s1_mx_q) * 64'(s1_mx_q);
    s2_sy_q    <= 64'(s1_my_q) * 64'(s1_my_q);
    s2_vsqx_q  <= 64'(s1_avx_q) * 64'(s1_avx_q);
    s2_vsqy_q  <= 64'(s1_avy_q) * 64'(s1_avy_q);
    s2_pnx_q   <= 63'(s1_mx_q) * 63'(s1_ps_q);
    s2_pny_q   <= 63'(s1_my_q) * 63'(s1_ps_q);
    s2_dvx_q   <= 63'(s1_avx_q) * 63'(dt);
    s2_dvy_q   <= 63'(s1_avy_q) * 63'(dt);
    s2_reach_q <= 62'(s1_ps_q) * 62'(dt);
  end

  // Stage 3: sums of squares, goal test and position advance.
  logic                 s3_vld_q;
  logic [1:0][RadW-1:0] s3_rad_q;
  sq_pay_t              s3_pay_q;
  logic [64:0]          lo_d, vlo_d;
  logic                 arrived_d;
  logic signed [SatW-1:0] px_ext, py_ext, stx, sty;
  sq_pay_t              s3_pay_d;

  always_comb begin
    lo_d      = {1'b0, s2_sx_q} + {1'b0, s2_sy_q};
    vlo_d     = {1'b0, s2_vsqx_q} + {1'b0, s2_vsqy_q};
    arrived_d = lo_d < {18'h0, s2_rsq_q, 16'h0};
    px_ext    = SatW'($signed(s2_px_q));
    py_ext    = SatW'($signed(s2_py_q));
    stx       = $signed({5'h0, s2_dvx_q[62:16]});
    sty       = $signed({5'h0, s2_dvy_q[62:16]});
    if (s2_vsx_q) begin
      stx = -stx;
    end
    if (s2_vsy_q) begin
      sty = -sty;
    end
    s3_pay_d.arrived = arrived_d;
    s3_pay_d.vzero   = s2_vzero_q;
    s3_pay_d.dsx     = s2_dsx_q;
    s3_pay_d.dsy     = s2_dsy_q;
    s3_pay_d.mx      = s2_mx_q;
    s3_pay_d.my      = s2_my_q;
    s3_pay_d.pnx     = s2_pnx_q;
    s3_pay_d.pny     = s2_pny_q;
    s3_pay_d.reach   = s2_reach_q;
    s3_pay_d.vsx     = s2_vsx_q;
    s3_pay_d.vsy     = s2_vsy_q;
    s3_pay_d.avx     = s2_avx_q;
    s3_pay_d.avy     = s2_avy_q;
    s3_pay_d.npx     = arrived_d ? s2_px_q : sat32(px_ext + stx);
    s3_pay_d.npy     = arrived_d ? s2_py_q : sat32(py_ext + sty);
    s3_pay_d.ox      = s2_ox_q;
    s3_pay_d.oy      = s2_oy_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s3_vld_q <= 1'b0;
    end else begin
      s3_vld_q <= s2_vld_q;
    end
  end

  always_ff @(posedge clk_i) begin
    s3_rad_q[0] <= {1'b0, lo_d};
    s3_rad_q[1] <= {1'b0, vlo_d};
    s3_pay_q    <= s3_pay_d;
  end

  // Square roots: goal distance and velocity norm.
  logic                  sq_vld;
  logic [1:0][RootW-1:0] sq_root;
  sq_pay_t               sq_pay;

  cagv_sqrt_pipe u_sqrt (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .vld_i  (s3_vld_q),
    .rad_i  (s3_rad_q),
    .pay_i  (s3_pay_q),
    .vld_o  (sq_vld),
    .root_o (sq_root),
    .pay_o  (sq_pay)
  );

  // Stage 4: reach test and divider operands.
  logic                   s4_vld_q;
  div_op_t [DivLanes-1:0] s4_op_q;
  dv_pay_t                s4_pay_q;
  div_op_t [DivLanes-1:0] op_d;
  dv_pay_t                s4_pay_d;
  logic                   reachable;

  always_comb begin
    reachable     = sq_pay.reach > {13'h0, sq_root[0], 16'h0};
    op_d[0].neg   = sq_pay.dsx;
    op_d[0].num   = reachable ? {16'h0, sq_pay.mx, 16'h0} : {1'b0, sq_pay.pnx};
    op_d[0].den   = reachable ? {2'b00, dt} : sq_root[0];
    op_d[1].neg   = sq_pay.dsy;
    op_d[1].num   = reachable ? {16'h0, sq_pay.my, 16'h0} : {1'b0, sq_pay.pny};
    op_d[1].den   = reachable ? {2'b00, dt} : sq_root[0];
    op_d[2].neg   = sq_pay.vsx;
    op_d[2].num   = {16'h0, sq_pay.avx, 16'h0};
    op_d[2].den   = sq_root[1];
    op_d[3].neg   = sq_pay.vsy;
    op_d[3].num   = {16'h0, sq_pay.avy, 16'h0};
    op_d[3].den   = sq_root[1];
    s4_pay_d.arrived = sq_pay.arrived;
    s4_pay_d.keep    = sq_pay.arrived || sq_pay.vzero;
    s4_pay_d.npx     = sq_pay.npx;
    s4_pay_d.npy     = sq_pay.npy;
    s4_pay_d.ox      = sq_pay.ox;
    s4_pay_d.oy      = sq_pay.oy;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s4_vld_q <= 1'b0;
    end else begin
      s4_vld_q <= sq_vld;
    end
  end

  always_ff @(posedge clk_i) begin
    s4_op_q  <= op_d;
    s4_pay_q <= s4_pay_d;
  end

  // Divisions: preferred velocity and normalized velocity.
  logic                    dv_vld;
  div_res_t [DivLanes-1:0] dv_res;
  dv_pay_t                 dv_pay;

  cagv_div_pipe u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .vld_i  (s4_vld_q),
    .op_i   (s4_op_q),
    .pay_i  (s4_pay_q),
    .vld_o  (dv_vld),
    .res_o  (dv_res),
    .pay_o  (dv_pay)
  );

  // Stage 5: signed, saturated quotients.
  logic        s5_vld_q;
  logic [31:0] s5_pvx_q, s5_pvy_q, s5_nx_q, s5_ny_q;
  dv_pay_t     s5_pay_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s5_vld_q <= 1'b0;
    end else begin
      s5_vld_q <= dv_vld;
    end
  end

  always_ff @(posedge clk_i) begin
    s5_pvx_q <= dv_pay.arrived ? '0 : quo_to_s32(dv_res[0]);
    s5_pvy_q <= dv_pay.arrived ? '0 : quo_to_s32(dv_res[1]);
    s5_nx_q  <= quo_to_s32(dv_res[2]);
    s5_ny_q  <= quo_to_s32(dv_res[3]);
    s5_pay_q <= dv_pay;
  end

  // Stage 6: blend products.
  logic               s6_vld_q;
  logic [31:0]        s6_pvx_q, s6_pvy_q;
  logic signed [50:0] s6_bx_q, s6_by_q;
  dv_pay_t            s6_pay_q;
  logic signed [33:0] dox, doy;

  assign dox = 34'($signed(s5_nx_q)) - 34'($signed(s5_pay_q.ox));
  assign doy = 34'($signed(s5_ny_q)) - 34'($signed(s5_pay_q.oy));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s6_vld_q <= 1'b0;
    end else begin
      s6_vld_q <= s5_vld_q;
    end
  end

  always_ff @(posedge clk_i) begin
    s6_pvx_q <= s5_pvx_q;
    s6_pvy_q <= s5_pvy_q;
    s6_bx_q  <= 51'(dox) * 51'($signed({1'b0, BlendQ16}));
    s6_by_q  <= 51'(doy) * 51'($signed({1'b0, BlendQ16}));
    s6_pay_q <= s5_pay_q;
  end

  // Stage 7: orientation update and result registers.
  logic                   done_q, arrived_q;
  logic [31:0]            pref_vel_x_q, pref_vel_y_q;
  logic [31:0]            new_pos_x_q, new_pos_y_q;
  logic [31:0]            new_orient_x_q, new_orient_y_q;
  logic signed [SatW-1:0] tx, ty;

  always_comb begin
    tx = SatW'(s6_bx_q >>> 16);
    ty = SatW'(s6_by_q >>> 16);
    if (s6_bx_q[50] && (s6_bx_q[15:0] != '0)) begin
      tx = tx + 52'sd1;
    end
    if (s6_by_q[50] && (s6_by_q[15:0] != '0)) begin
      ty = ty + 52'sd1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      done_q <= 1'b0;
    end else begin
      done_q <= s6_vld_q;
    end
  end

  always_ff @(posedge clk_i) begin
    arrived_q      <= s6_pay_q.arrived;
    pref_vel_x_q   <= s6_pvx_q;
    pref_vel_y_q   <= s6_pvy_q;
    new_pos_x_q    <= s6_pay_q.npx;
    new_pos_y_q    <= s6_pay_q.npy;
    new_orient_x_q <= s6_pay_q.keep ? s6_pay_q.ox :
                      sat32(SatW'($signed(s6_pay_q.ox)) + tx);
    new_orient_y_q <= s6_pay_q.keep ? s6_pay_q.oy :
                      sat32(SatW'($signed(s6_pay_q.oy)) + ty);
  end

  assign done_o         = done_q;
  assign arrived_o      = arrived_q;
  assign pref_vel_x_o   = pref_vel_x_q;
  assign pref_vel_y_o   = pref_vel_y_q;
  assign new_pos_x_o    = new_pos_x_q;
  assign new_pos_y_o    = new_pos_y_q;
  assign new_orient_x_o = new_orient_x_q;
  assign new_orient_y_o = new_orient_y_q;

  `CAGV_ASSERT_IMPLY(a_arrived_zero_vel, done_q && arrived_q, pref_vel_x_q == '0 && pref_vel_y_q == '0)
  `CAGV_ASSERT_DELAY(a_sqrt_to_div, sq_vld, 34, dv_vld)
  `CAGV_ASSERT_DELAY(a_div_to_done, dv_vld, 3, done_q)

endmodule

[verif/crowd_agent_goal_velocity_step_checker.sv]
// ----------------------------------------------------------------------------
// Crowd agent step checker
// Watches the request, result and register channels of the agent step block,
// computes the expected result of every accepted request in order, and
// compares each strobed result field by field against the oldest one.
// ----------------------------------------------------------------------------
module crowd_agent_goal_velocity_step_checker
  import cagv_pkg::*;
(
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             psel,
  input  logic             penable,
  input  logic             pwrite,
  input  logic [AddrW-1:0] paddr,
  input  logic [31:0]      pwdata,
  input  logic             pready,
  input  logic             start,
  input  logic             busy,
  input  logic [31:0]      pos_x_i,
  input  logic [31:0]      pos_y_i,
  input  logic [31:0]      goal_x_i,
  input  logic [31:0]      goal_y_i,
  input  logic [31:0]      vel_x_i,
  input  logic [31:0]      vel_y_i,
  input  logic [31:0]      orient_x_i,
  input  logic [31:0]      orient_y_i,
  input  logic [30:0]      pref_speed_i,
  input  logic [30:0]      goal_radius_sq_i,
  input  logic             done_o,
  input  logic [31:0]      pref_vel_x_o,
  input  logic [31:0]      pref_vel_y_o,
  input  logic             arrived_o,
  input  logic [31:0]      new_pos_x_o,
  input  logic [31:0]      new_pos_y_o,
  input  logic [31:0]      new_orient_x_o,
  input  logic [31:0]      new_orient_y_o,
  output int               fail_count,
  output int               pending
);
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    logic [31:0] pvx;
    logic [31:0] pvy;
    logic        arr;
    logic [31:0] npx;
    logic [31:0] npy;
    logic [31:0] nox;
    logic [31:0] noy;
  } agent_update_t;

  agent_update_t  step_queue[$];
  logic [30:0]    dt_reg;

  function automatic logic [32:0] root_of(input logic [65:0] v);
    logic [32:0] root;
    logic [67:0] rem;
    logic [67:0] trial;
    root = '0;
    rem = '0;
    for (int i = 32; i >= 0; i--) begin
      rem = (rem << 2) | v[2*i +: 2];
      trial = ({35'd0, root} << 2) | 68'd1;
      if (rem >= trial) begin
        rem = rem - trial;
        root = (root << 1) | 33'd1;
      end else begin
        root = root << 1;
      end
    end
    return root;
  endfunction

  function automatic logic signed [127:0] trunc_div(input logic signed [127:0] num,
                                                     input logic signed [127:0] den);
    logic signed [127:0] q;
    if (den == 0) begin
      return 0;
    end
    q = (num < 0 ? -num : num) / den;
    return num < 0 ? -q : q;
  endfunction

  function automatic logic [31:0] clamp32(input logic signed [127:0] v);
    if (v > 128'sd2147483647) begin
      return 32'h7fff_ffff;
    end
    if (v < -128'sd2147483648) begin
      return 32'h8000_0000;
    end
    return v[31:0];
  endfunction

  function automatic agent_update_t agent_step(input logic signed [31:0] px,
      input logic signed [31:0] py, input logic signed [31:0] gx,
      input logic signed [31:0] gy, input logic signed [31:0] vx,
      input logic signed [31:0] vy, input logic signed [31:0] ox,
      input logic signed [31:0] oy, input logic [30:0] ps,
      input logic [30:0] rsq, input logic [30:0] dt);
    agent_update_t r;
    logic signed [127:0] dx;
    logic signed [127:0] dy;
    logic signed [127:0] dsq;
    logic signed [127:0] gdist;
    logic signed [127:0] vnorm;
    logic signed [127:0] nx;
    logic signed [127:0] ny;
    logic signed [127:0] dtw;
    logic signed [127:0] psw;
    dx = 128'(gx) - 128'(px);
    dy = 128'(gy) - 128'(py);
    dsq = dx * dx + dy * dy;
    dtw = {97'd0, dt};
    psw = {97'd0, ps};
    r.pvx = '0;
    r.pvy = '0;
    r.npx = px;
    r.npy = py;
    r.nox = ox;
    r.noy = oy;
    r.arr = dsq < ({97'd0, rsq} <<< 16);
    if (!r.arr) begin
      gdist = {95'd0, root_of(dsq[65:0])};
      if (psw * dtw > (gdist <<< 16)) begin
        r.pvx = clamp32(trunc_div(dx <<< 16, dtw));
        r.pvy = clamp32(trunc_div(dy <<< 16, dtw));
      end else if (gdist != 0) begin
        r.pvx = clamp32(trunc_div(dx * psw, gdist));
        r.pvy = clamp32(trunc_div(dy * psw, gdist));
      end
      r.npx = clamp32(128'(px) + trunc_div(128'(vx) * dtw, 128'sd65536));
      r.npy = clamp32(128'(py) + trunc_div(128'(vy) * dtw, 128'sd65536));
      if (vx != 0 || vy != 0) begin
        dsq = 128'(vx) * 128'(vx) + 128'(vy) * 128'(vy);
        vnorm = {95'd0, root_of(dsq[65:0])};
        nx = trunc_div(128'(vx) <<< 16, vnorm);
        ny = trunc_div(128'(vy) <<< 16, vnorm);
        r.nox = clamp32(128'(ox) + trunc_div((nx - 128'(ox)) * 128'(BlendQ16),
                                             128'sd65536));
        r.noy = clamp32(128'(oy) + trunc_div((ny - 128'(oy)) * 128'(BlendQ16),
                                             128'sd65536));
      end
    end
    return r;
  endfunction

  task automatic report_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] want);
    $display("%0t: %s got %h expected %h", $realtime, what, got, want);
    fail_count++;
  endtask

  always_ff @(posedge clk_i or negedge rst_ni) begin
    agent_update_t want;
    if (!rst_ni) begin
      dt_reg <= TimeStepReset;
      fail_count = 0;
      pending <= 0;
      step_queue.delete();
    end else begin
      if (psel && penable && pwrite && pready && paddr[AddrW-1:2] == RegTimeStep) begin
        dt_reg <= pwdata[30:0];
      end
      if (done_o) begin
        if (step_queue.size() == 0) begin
          report_mismatch("unexpected result", 32'd0, 32'd0);
        end else begin
          want = step_queue.pop_front();
          if (pref_vel_x_o !== want.pvx) report_mismatch("pref_vel_x", pref_vel_x_o, want.pvx);
          if (pref_vel_y_o !== want.pvy) report_mismatch("pref_vel_y", pref_vel_y_o, want.pvy);
          if (arrived_o !== want.arr) report_mismatch("arrived", 32'(arrived_o), 32'(want.arr));
          if (new_pos_x_o !== want.npx) report_mismatch("new_pos_x", new_pos_x_o, want.npx);
          if (new_pos_y_o !== want.npy) report_mismatch("new_pos_y", new_pos_y_o, want.npy);
          if (new_orient_x_o !== want.nox) report_mismatch("new_orient_x", new_orient_x_o, want.nox);
          if (new_orient_y_o !== want.noy) report_mismatch("new_orient_y", new_orient_y_o, want.noy);
        end
      end
      if (start && !busy) begin
        step_queue = {step_queue, agent_step(pos_x_i, pos_y_i, goal_x_i, goal_y_i, vel_x_i,
            vel_y_i, orient_x_i, orient_y_i, pref_speed_i, goal_radius_sq_i, dt_reg)};
      end
      pending <= step_queue.size();
    end
  end
endmodule

[verif/testbench.sv]
// ----------------------------------------------------------------------------
// Crowd agent step testbench
// Sets the time step through the register port in several phases, sends
// directed and random agent requests with random gaps, and reports the
// checker's verdict.
// ----------------------------------------------------------------------------
module testbench
  import cagv_pkg::*;
();
  timeunit 1ns;
  timeprecision 1ps;

  logic             clk_i = 1'b0;
  logic             rst_ni = 1'b0;
  logic             psel = 1'b0;
  logic             penable = 1'b0;
  logic             pwrite = 1'b0;
  logic [AddrW-1:0] paddr = '0;
  logic [31:0]      pwdata = '0;
  logic [31:0]      prdata;
  logic             pready;
  logic             start = 1'b0;
  logic             busy;
  logic [31:0]      pos_x_i = '0;
  logic [31:0]      pos_y_i = '0;
  logic [31:0]      goal_x_i = '0;
  logic [31:0]      goal_y_i = '0;
  logic [31:0]      vel_x_i = '0;
  logic [31:0]      vel_y_i = '0;
  logic [31:0]      orient_x_i = '0;
  logic [31:0]      orient_y_i = '0;
  logic [30:0]      pref_speed_i = '0;
  logic [30:0]      goal_radius_sq_i = '0;
  logic             done_o;
  logic [31:0]      pref_vel_x_o;
  logic [31:0]      pref_vel_y_o;
  logic             arrived_o;
  logic [31:0]      new_pos_x_o;
  logic [31:0]      new_pos_y_o;
  logic [31:0]      new_orient_x_o;
  logic [31:0]      new_orient_y_o;
  int               fail_count;
  int               pending;
  int               cycle_count = 0;
  bit               calm;

  crowd_agent_goal_velocity_step dut (.*);
  crowd_agent_goal_velocity_step_checker checker_i (.*);

  initial begin
    forever #1 clk_i = ~clk_i;
  end

  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count > 400000) begin
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

  task automatic set_time_step(input logic [30:0] dt);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= AddrW'(RegTimeStep) << 2;
    pwdata <= {1'b0, dt};
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
  endtask

  task automatic send_agent(input logic [31:0] px, input logic [31:0] py,
      input logic [31:0] gx, input logic [31:0] gy, input logic [31:0] vx,
      input logic [31:0] vy, input logic [31:0] ox, input logic [31:0] oy,
      input logic [30:0] ps, input logic [30:0] rsq);
    while (!calm && $urandom_range(99) < 28) begin
      start <= 1'b0;
      @(posedge clk_i);
    end
    start <= 1'b1;
    pos_x_i <= px;
    pos_y_i <= py;
    goal_x_i <= gx;
    goal_y_i <= gy;
    vel_x_i <= vx;
    vel_y_i <= vy;
    orient_x_i <= ox;
    orient_y_i <= oy;
    pref_speed_i <= ps;
    goal_radius_sq_i <= rsq;
    do @(posedge clk_i); while (busy);
  endtask

  function automatic logic [31:0] near_val(input logic [31:0] base);
    return base + 32'($signed($urandom_range(0, 2**20)) - 2**19);
  endfunction

  task automatic random_agent();
    logic [31:0] px;
    logic [31:0] py;
    logic [31:0] vx;
    logic [31:0] vy;
    int mode;
    mode = $urandom_range(9);
    px = (mode < 7) ? 32'($signed($urandom_range(0, 2**26)) - 2**25) : $urandom;
    py = (mode < 7) ? 32'($signed($urandom_range(0, 2**26)) - 2**25) : $urandom;
    vx = (mode == 3) ? 32'd0 : (mode < 7) ? near_val(32'd0) : $urandom;
    vy = (mode == 3) ? 32'd0 : (mode < 7) ? near_val(32'd0) : $urandom;
    send_agent(px, py, (mode < 7) ? near_val(px) : $urandom,
        (mode < 7) ? near_val(py) : $urandom, vx, vy,
        (mode < 8) ? near_val(32'd0) : $urandom, (mode < 8) ? near_val(32'd0) : $urandom,
        (mode < 5) ? 31'($urandom_range(0, 2**22)) : 31'($urandom),
        (mode < 6) ? 31'($urandom_range(0, 2**20)) : 31'($urandom));
  endtask

  task automatic drain();
    start <= 1'b0;
    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
    repeat (80) @(posedge clk_i);
  endtask

  initial begin
    calm = 1'b0;
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    send_agent(0, 0, 0, 0, 0, 0, 32'h10000, 0, 31'h10000, 31'h10000);
    send_agent(0, 0, 32'h10000, 0, 32'h10000, 0, 0, 32'h10000, 31'h10000, 0);
    send_agent(0, 0, 0, 0, 32'h20000, 32'h30000, 5, 7, 31'h7fffffff, 0);
    send_agent(32'h80000000, 32'h80000000, 32'h7fffffff, 32'h7fffffff, 32'h80000000,
        32'h80000000, 32'h80000000, 32'h80000000, 31'h7fffffff, 31'h7fffffff);
    send_agent(32'h7fffffff, 32'h7fffffff, 32'h80000000, 32'h80000000, 32'h7fffffff,
        32'h7fffffff, 32'h7fffffff, 32'h7fffffff, 31'h7fffffff, 0);
    send_agent(32'h7fffffff, 32'h80000000, 32'h80000000, 32'h7fffffff, 32'h7fffffff,
        32'h80000000, 32'hffffffff, 32'h1, 0, 0);
    send_agent(0, 0, 32'h50000, 32'h50000, 32'h10000, 0, 0, 0, 31'h1, 31'h7fffffff);
    send_agent(0, 0, 32'h8000, 0, 0, 32'hffff0000, 0, 0, 31'h100000, 0);
    send_agent(100, 100, 100, 100, 0, 0, 3, 3, 0, 0);
    drain();
    for (int phase = 0; phase < 5; phase++) begin
      case (phase)
        0: set_time_step(31'd1);
        1: set_time_step(31'h7fffffff);
        2: set_time_step(31'd65536);
        3: set_time_step(31'($urandom_range(1, 2**20)));
        default: set_time_step(31'd6554);
      endcase
      if (phase == 1) begin
        send_agent(0, 0, 32'h10, 0, 32'h7fffffff, 32'h80000000, 0, 0, 31'h7fffffff, 0);
      end
      for (int n = 0; n < 228; n++) begin
        calm = (phase == 2 && n < 120);
        random_agent();
      end
      calm = 1'b0;
      drain();
    end
    if (fail_count == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end
endmodule

[sim.f]
+incdir+rtl
rtl/cagv_pkg.sv
rtl/cagv_cfg_regs.sv
rtl/cagv_sqrt_pipe.sv
rtl/cagv_div_pipe.sv
rtl/crowd_agent_goal_velocity_step.sv
verif/crowd_agent_goal_velocity_step_checker.sv
verif/testbench.sv
